/* rtl/imd_pkg.sv */
// shared types and constants of the integer matrix determinant unit
// no dependencies
package imd_pkg;

  // configuration register indexes
  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NOT_SQUARE = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW   = 2'd2;

  // magnitude bound of every intermediate value, 2^63-1, held in 65 bits
  localparam logic signed [64:0] MAG_LIMIT = {2'b00, {63{1'b1}}};
  localparam logic signed [63:0] DET_MAX   = 64'sd2147483647;
  localparam logic signed [63:0] DET_MIN   = -64'sd2147483648;

  // iterations of the serial arithmetic units
  localparam logic [6:0] SERIAL_STEPS = 7'd64;

  typedef enum logic [4:0] {
    S_LOAD,
    S_PIV_RD,
    S_PIV_CHK,
    S_SW_RK,
    S_SW_RP,
    S_SW_WK,
    S_SW_WP,
    S_KK_RD,
    S_KK_CAP,
    S_IK_RD,
    S_IK_CAP,
    S_KJ_RD,
    S_IJ_RD,
    S_MUL_GO,
    S_MUL_WAIT,
    S_SUB,
    S_DIV_WAIT,
    S_K_END,
    S_FIN_RD,
    S_FIN_CAP
  } imd_state_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic signed [63:0] prod;
  } imd_mul_res_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quot;
  } imd_div_res_t;

endpackage

/* rtl/imd_mul.sv */
// serial checked multiplier, one operand bit per cycle, msb first
// depends on imd_pkg
module imd_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [63:0]    op_a,
  input  logic signed [63:0]    op_b,
  output imd_pkg::imd_mul_res_t res
);
  import imd_pkg::*;

  logic [63:0] ua_r;
  logic [63:0] ub_r;
  logic [63:0] acc_r;
  logic        neg_r;
  logic        ovf_r;
  logic [6:0]  cnt_r;
  logic        done_r;
  logic [65:0] sum;

  // double the partial product and add the multiplicand when the bit is set
  assign sum = {1'b0, acc_r, 1'b0} + (ub_r[63] ? {2'b00, ua_r} : 66'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= SERIAL_STEPS;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands as magnitudes, sign kept apart
  always_ff @(posedge clk) begin
    if (start) begin
      ua_r  <= op_a[63] ? 64'(-op_a) : 64'(op_a);
      ub_r  <= op_b[63] ? 64'(-op_b) : 64'(op_b);
      neg_r <= op_a[63] ^ op_b[63];
      acc_r <= '0;
      ovf_r <= 1'b0;
    end else if (cnt_r != '0) begin
      acc_r <= sum[63:0];
      ub_r  <= {ub_r[62:0], 1'b0};
      ovf_r <= ovf_r | (sum[65:63] != 3'd0);
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.prod = neg_r ? -$signed(acc_r) : $signed(acc_r);

endmodule

/* rtl/imd_div.sv */
// serial restoring divider, one quotient bit per cycle
// depends on imd_pkg
module imd_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [63:0]    dividend,
  input  logic signed [63:0]    divisor,
  output imd_pkg::imd_div_res_t res
);
  import imd_pkg::*;

  logic [63:0] quo_r;
  logic [64:0] rem_r;
  logic [63:0] dv_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        done_r;
  logic [64:0] shifted;
  logic        fits;

  assign shifted = {rem_r[63:0], quo_r[63]};
  assign fits    = shifted >= {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= SERIAL_STEPS;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // magnitude division, quotient sign applied at the output
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[63] ? 64'(-dividend) : 64'(dividend);
      dv_r  <= divisor[63] ? 64'(-divisor) : 64'(divisor);
      neg_r <= dividend[63] ^ divisor[63];
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? (shifted - {1'b0, dv_r}) : shifted;
      quo_r <= {quo_r[62:0], fits};
    end
  end

  assign res.done = done_r;
  assign res.quot = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

/* rtl/integer_matrix_determinant_unit.sv */
// top level: matrix store, load counters and elimination sequencer
// depends on imd_pkg, imd_mul and imd_div
//
// Elements are taken one per cycle (start high while busy is low) in
// row-major order into a single store of 64-bit words with a registered read.
// A non-square matrix gives its result on out_valid in the cycle after the last
// element and busy stays low. A square matrix raises busy after the last
// element while fraction-free elimination runs out of the store: each updated
// entry takes two store reads, then two serial multipliers run side by side,
// then a subtract step and a serial divider; pivot search and row swaps (two
// reads and two writes per swapped column) come on top.
// The result appears on out_valid for exactly one cycle and cannot be held off
// by the receiver.
module integer_matrix_determinant_unit #(
  parameter int MAX_DIM = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_element,
  output logic               out_valid,
  output logic signed [31:0] out_det_value,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data
);
  import imd_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_DIM + 1);

  // store
  logic signed [63:0] store_r [DEPTH];
  logic signed [63:0] rdata_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic signed [63:0] mem_wdata;

  // sequencer state
  imd_state_t         state_r, state_nxt;
  logic [CW-1:0]      k_r, k_nxt, p_r, p_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]      lrow_r, lrow_nxt, lcol_r, lcol_nxt;
  logic [3:0]         row_count_r, row_count_nxt, col_count_r, col_count_nxt;
  logic signed [63:0] mkk_r, mkk_nxt, mik_r, mik_nxt, mkj_r, mkj_nxt;
  logic signed [63:0] prev_r, prev_nxt, tk_r, tk_nxt, pa_r, pa_nxt, pb_r, pb_nxt;
  logic               sign_r, sign_nxt, movf_r, movf_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_det_r, out_det_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  // arithmetic units
  logic               mul_start, div_start;
  imd_mul_res_t       mul_a_res, mul_b_res;
  imd_div_res_t       div_res;
  logic signed [64:0] diff;
  logic signed [63:0] fin_v;
  logic [CW-1:0]      n_rows, n_cols;

  function automatic logic [CW-1:0] clamp_dim(input logic [3:0] v);
    logic [CW-1:0] r;
    if (v == 4'd0) begin
      r = CW'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = CW'(MAX_DIM);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] row,
                                            input logic [CW-1:0] col);
    return AW'(32'(row) * MAX_DIM + 32'(col));
  endfunction

  assign n_rows = clamp_dim(row_count_r);
  assign n_cols = clamp_dim(col_count_r);

  // store write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= store_r[mem_raddr];
  end

  imd_mul u_mul_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mkk_r),
    .op_b  (rdata_r),
    .res   (mul_a_res)
  );

  imd_mul u_mul_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mik_r),
    .op_b  (mkj_r),
    .res   (mul_b_res)
  );

  imd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff[63:0]),
    .divisor  (prev_r),
    .res      (div_res)
  );

  assign diff  = {pa_r[63], pa_r} - {pb_r[63], pb_r};
  assign fin_v = sign_r ? -rdata_r : rdata_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      lrow_r       <= '0;
      lcol_r       <= '0;
      row_count_r  <= 4'd1;
      col_count_r  <= 4'd1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      lrow_r       <= lrow_nxt;
      lcol_r       <= lcol_nxt;
      row_count_r  <= row_count_nxt;
      col_count_r  <= col_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    p_r          <= p_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    mkk_r        <= mkk_nxt;
    mik_r        <= mik_nxt;
    mkj_r        <= mkj_nxt;
    prev_r       <= prev_nxt;
    tk_r         <= tk_nxt;
    pa_r         <= pa_nxt;
    pb_r         <= pb_nxt;
    sign_r       <= sign_nxt;
    movf_r       <= movf_nxt;
    out_det_r    <= out_det_nxt;
    out_status_r <= out_status_nxt;
  end

  // next state, store access and unit control
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    p_nxt          = p_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    lrow_nxt       = lrow_r;
    lcol_nxt       = lcol_r;
    row_count_nxt  = row_count_r;
    col_count_nxt  = col_count_r;
    mkk_nxt        = mkk_r;
    mik_nxt        = mik_r;
    mkj_nxt        = mkj_r;
    prev_nxt       = prev_r;
    tk_nxt         = tk_r;
    pa_nxt         = pa_r;
    pb_nxt         = pb_r;
    sign_nxt       = sign_r;
    movf_nxt       = movf_r;
    out_valid_nxt  = 1'b0;
    out_det_nxt    = out_det_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = addr_of(lrow_r, lcol_r);
    mem_wdata      = 64'(in_element);
    mem_raddr      = addr_of(p_r, k_r);
    mul_start      = 1'b0;
    div_start      = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (start) begin
          mem_we = 1'b1;
          if (lcol_r + CW'(1) == n_cols) begin
            lcol_nxt = '0;
            if (lrow_r + CW'(1) == n_rows) begin
              lrow_nxt = '0;
              if (n_rows != n_cols) begin
                out_valid_nxt  = 1'b1;
                out_det_nxt    = '0;
                out_status_nxt = STAT_NOT_SQUARE;
              end else begin
                k_nxt     = '0;
                p_nxt     = '0;
                sign_nxt  = 1'b0;
                prev_nxt  = 64'sd1;
                state_nxt = S_PIV_RD;
              end
            end else begin
              lrow_nxt = lrow_r + CW'(1);
            end
          end else begin
            lcol_nxt = lcol_r + CW'(1);
          end
        end
      end

      // pivot search down column k
      S_PIV_RD: begin
        mem_raddr = addr_of(p_r, k_r);
        state_nxt = S_PIV_CHK;
      end
      S_PIV_CHK: begin
        if (rdata_r != 64'sd0) begin
          j_nxt     = '0;
          state_nxt = (p_r == k_r) ? S_KK_RD : S_SW_RK;
        end else if (p_r + CW'(1) == n_rows) begin
          out_valid_nxt  = 1'b1;
          out_det_nxt    = '0;
          out_status_nxt = STAT_OK;
          state_nxt      = S_LOAD;
        end else begin
          p_nxt     = p_r + CW'(1);
          state_nxt = S_PIV_RD;
        end
      end

      // row swap, one column at a time: read both entries, then write both
      S_SW_RK: begin
        mem_raddr = addr_of(k_r, j_r);
        state_nxt = S_SW_RP;
      end
      S_SW_RP: begin
        mem_raddr = addr_of(p_r, j_r);
        tk_nxt    = rdata_r;
        state_nxt = S_SW_WK;
      end
      S_SW_WK: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(k_r, j_r);
        mem_wdata = rdata_r;
        state_nxt = S_SW_WP;
      end
      S_SW_WP: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(p_r, j_r);
        mem_wdata = tk_r;
        if (j_r + CW'(1) == n_rows) begin
          sign_nxt  = ~sign_r;
          state_nxt = S_KK_RD;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_SW_RK;
        end
      end

      // pivot value
      S_KK_RD: begin
        mem_raddr = addr_of(k_r, k_r);
        state_nxt = S_KK_CAP;
      end
      S_KK_CAP: begin
        mkk_nxt = rdata_r;
        if (k_r + CW'(1) == n_rows) begin
          state_nxt = S_K_END;
        end else begin
          i_nxt     = k_r + CW'(1);
          state_nxt = S_IK_RD;
        end
      end

      // row i below the pivot
      S_IK_RD: begin
        mem_raddr = addr_of(i_r, k_r);
        state_nxt = S_IK_CAP;
      end
      S_IK_CAP: begin
        mik_nxt   = rdata_r;
        j_nxt     = k_r + CW'(1);
        state_nxt = S_KJ_RD;
      end

      // entry update: (mkk*mij - mik*mkj) / prev
      S_KJ_RD: begin
        mem_raddr = addr_of(k_r, j_r);
        state_nxt = S_IJ_RD;
      end
      S_IJ_RD: begin
        mem_raddr = addr_of(i_r, j_r);
        mkj_nxt   = rdata_r;
        state_nxt = S_MUL_GO;
      end
      S_MUL_GO: begin
        mul_start = 1'b1;
        state_nxt = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (mul_a_res.done) begin
          pa_nxt    = mul_a_res.prod;
          pb_nxt    = mul_b_res.prod;
          movf_nxt  = mul_a_res.ovf | mul_b_res.ovf;
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        if (movf_r || diff > MAG_LIMIT || diff < -MAG_LIMIT) begin
          out_valid_nxt  = 1'b1;
          out_det_nxt    = '0;
          out_status_nxt = STAT_OVERFLOW;
          state_nxt      = S_LOAD;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_res.done) begin
          mem_we    = 1'b1;
          mem_waddr = addr_of(i_r, j_r);
          mem_wdata = div_res.quot;
          if (j_r + CW'(1) != n_rows) begin
            j_nxt     = j_r + CW'(1);
            state_nxt = S_KJ_RD;
          end else if (i_r + CW'(1) != n_rows) begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_IK_RD;
          end else begin
            state_nxt = S_K_END;
          end
        end
      end

      // next column
      S_K_END: begin
        prev_nxt = mkk_r;
        if (k_r + CW'(1) == n_rows) begin
          state_nxt = S_FIN_RD;
        end else begin
          k_nxt     = k_r + CW'(1);
          p_nxt     = k_r + CW'(1);
          state_nxt = S_PIV_RD;
        end
      end

      // last diagonal entry is the determinant
      S_FIN_RD: begin
        mem_raddr = addr_of(n_rows - CW'(1), n_rows - CW'(1));
        state_nxt = S_FIN_CAP;
      end
      S_FIN_CAP: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_LOAD;
        if (fin_v > DET_MAX || fin_v < DET_MIN) begin
          out_det_nxt    = '0;
          out_status_nxt = STAT_OVERFLOW;
        end else begin
          out_det_nxt    = fin_v[31:0];
          out_status_nxt = STAT_OK;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // a register write restarts loading
    if (cfg_we) begin
      lrow_nxt = '0;
      lcol_nxt = '0;
      if (cfg_index == CFG_ROW_COUNT) begin
        row_count_nxt = cfg_data;
      end else if (cfg_index == CFG_COL_COUNT) begin
        col_count_nxt = cfg_data;
      end
    end
  end

  assign busy          = (state_r != S_LOAD);
  assign out_valid     = out_valid_r;
  assign out_det_value = out_det_r;
  assign out_status    = out_status_r;

endmodule

/* rtl/imd_checker.sv */
// port-level checks of the integer matrix determinant unit, bound to the top
// depends on imd_pkg and integer_matrix_determinant_unit
module imd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] out_det_value,
  input logic [1:0]         out_status
);
  import imd_pkg::*;

  // reset leaves the unit idle with no result
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("unit not idle after reset");

  // at most one result per matrix, never in two adjacent cycles
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in adjacent cycles");

  // failed status carries a zero determinant
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_det_value == 32'sd0)
    else $error("nonzero determinant with error status");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STAT_OK || out_status == STAT_NOT_SQUARE ||
                  out_status == STAT_OVERFLOW)
    else $error("undefined status code");

  // busy falls at the end of elimination only together with a result
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("elimination ended without a result");

endmodule

bind integer_matrix_determinant_unit imd_checker u_imd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_det_value (out_det_value),
  .out_status    (out_status)
);
